// ===== src/byte_ring_buffer_block_transfer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the byte ring buffer block transfer unit
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_BLOCK_TRANSFER_UNIT_MACROS_SVH
`define BYTE_RING_BUFFER_BLOCK_TRANSFER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define BRB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BRB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BRB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BRB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/brb_pkg.sv =====
// ----------------------------------------------------------------------------
// brb_pkg
// Shared constants and codes for the byte ring buffer block transfer unit.
// ----------------------------------------------------------------------------
package brb_pkg;

	localparam int MAX_CAPACITY   = 1023;
	localparam int BYTES_PER_ITEM = 8;
	localparam int ADDR_W         = 10;
	localparam int BANKS          = 8;
	localparam int BANK_W         = 3;
	localparam int ROWS           = (MAX_CAPACITY + 1) / BANKS;
	localparam int ROW_W          = ADDR_W - BANK_W;
	localparam int CNT_W          = 4;
	localparam int ACT_W          = 2;
	localparam int STAT_W         = 2;
	localparam int DATA_W         = 8 * BYTES_PER_ITEM;

	typedef enum logic [ACT_W-1:0] {
		ACT_ENQ  = 2'd0,
		ACT_DEQ  = 2'd1,
		ACT_PEEK = 2'd2,
		ACT_NOP  = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_NO_DATA  = 2'd2
	} status_t;

endpackage

// ===== src/byte_ring_buffer_block_transfer_unit.sv =====
// Pipeline: an accepted request's result is registered in stage one, then in the output registers.
// Throughput: one request per cycle unless out_ready stalls the output; eight
// byte-wide RAM banks, each with one write and one read port, move a whole block in
// the accept cycle. Reset: both pointers go to zero and capacity to 1023; store contents
// stay undefined until written. A capacity write also empties the buffer.
// ----------------------------------------------------------------------------
// byte_ring_buffer_block_transfer_unit
// Byte FIFO with all-or-nothing block enqueue, dequeue and peek of up to
// eight bytes, reporting used and free byte counts with each result.
// ----------------------------------------------------------------------------
`include "byte_ring_buffer_block_transfer_unit_macros.svh"

module byte_ring_buffer_block_transfer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [brb_pkg::ADDR_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [brb_pkg::ACT_W-1:0]   action,
	input  logic [brb_pkg::CNT_W-1:0]   byte_count,
	input  logic [brb_pkg::DATA_W-1:0]  write_bytes,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [brb_pkg::STAT_W-1:0]  status,
	output logic [brb_pkg::DATA_W-1:0]  read_bytes,
	output logic [brb_pkg::CNT_W-1:0]   transferred,
	output logic [brb_pkg::ADDR_W-1:0]  used_count,
	output logic [brb_pkg::ADDR_W-1:0]  free_count
);
	import brb_pkg::*;

	// Bytes live at stream positions; position p sits in bank p mod 8, row p / 8.
	// At most 1023 bytes are stored, so a 10-bit position never aliases.
	logic [ADDR_W-1:0] cap_q, wptr_q, rptr_q;
	logic [ADDR_W-1:0] used_cur, free_cur, used_new;
	logic [CNT_W-1:0]  cnt;
	logic [ADDR_W-1:0] cnt_ext;
	logic              wr_go, rd_go, pop;
	status_t           stat_nxt;
	logic              accept, s1_go;

	logic              valid_s1;
	status_t           status_s1;
	logic [CNT_W-1:0]  moved_s1, rcount_s1;
	logic [ADDR_W-1:0] used_s1, free_s1;
	logic [BANK_W-1:0] rbase_s1;

	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [DATA_W-1:0] rdata_q;
	logic [CNT_W-1:0]  moved_q;
	logic [ADDR_W-1:0] used_q, free_q;

	logic [BANKS-1:0]  bank_we;
	logic [ROW_W-1:0]  bank_waddr [BANKS];
	logic [7:0]        bank_wdata [BANKS];
	logic [ROW_W-1:0]  bank_raddr [BANKS];
	logic [7:0]        bank_rdata [BANKS];
	logic [DATA_W-1:0] rd_bytes;

	assign s1_go    = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || s1_go;
	assign accept   = in_valid && in_ready;

	assign cnt      = (byte_count > CNT_W'(BYTES_PER_ITEM)) ? CNT_W'(BYTES_PER_ITEM)
		: byte_count;
	assign cnt_ext  = ADDR_W'(cnt);
	assign used_cur = wptr_q - rptr_q;
	assign free_cur = cap_q - used_cur;

	always_comb begin
		wr_go    = 1'b0;
		rd_go    = 1'b0;
		pop      = 1'b0;
		stat_nxt = ST_OK;
		unique case (action_t'(action))
			ACT_ENQ: begin
				if (cnt_ext > free_cur) begin
					stat_nxt = ST_NO_SPACE;
				end else begin
					wr_go = 1'b1;
				end
			end
			ACT_DEQ, ACT_PEEK: begin
				if (cnt_ext > used_cur) begin
					stat_nxt = ST_NO_DATA;
				end else begin
					rd_go = 1'b1;
					pop   = (action_t'(action) == ACT_DEQ);
				end
			end
			default: begin
				stat_nxt = ST_OK;
			end
		endcase
	end

	always_comb begin
		if (wr_go) begin
			used_new = used_cur + cnt_ext;
		end else if (pop) begin
			used_new = used_cur - cnt_ext;
		end else begin
			used_new = used_cur;
		end
	end

	// Spread the block over the banks; bank b gets the byte whose position ends in b
	always_comb begin
		logic [BANK_W-1:0] woff;
		for (int b = 0; b < BANKS; b++) begin
			woff          = BANK_W'(b) - wptr_q[BANK_W-1:0];
			bank_we[b]    = accept && wr_go && (CNT_W'(woff) < cnt);
			bank_waddr[b] = wptr_q[ADDR_W-1:BANK_W]
				+ ROW_W'(BANK_W'(b) < wptr_q[BANK_W-1:0]);
			bank_wdata[b] = write_bytes[8*woff +: 8];
			bank_raddr[b] = rptr_q[ADDR_W-1:BANK_W]
				+ ROW_W'(BANK_W'(b) < rptr_q[BANK_W-1:0]);
		end
	end

	for (genvar gb = 0; gb < BANKS; gb++) begin : g_bank
		brb_ram #(
			.WIDTH (8),
			.DEPTH (ROWS)
		) u_ram (
			.clk   (clk),
			.we    (bank_we[gb]),
			.waddr (bank_waddr[gb]),
			.wdata (bank_wdata[gb]),
			.re    (accept && rd_go),
			.raddr (bank_raddr[gb]),
			.rdata (bank_rdata[gb])
		);
	end

	// Rotate the bank outputs back into block order, zero past the count
	always_comb begin
		logic [BANK_W-1:0] bsel;
		for (int i = 0; i < BYTES_PER_ITEM; i++) begin
			bsel = rbase_s1 + BANK_W'(i);
			rd_bytes[8*i +: 8] = (CNT_W'(i) < rcount_s1) ? bank_rdata[bsel] : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= ADDR_W'(MAX_CAPACITY);
			wptr_q <= '0;
			rptr_q <= '0;
		end else if (cfg_write) begin
			cap_q  <= (cfg_data == '0) ? ADDR_W'(1) : cfg_data;
			wptr_q <= '0;
			rptr_q <= '0;
		end else if (accept) begin
			if (wr_go) begin
				wptr_q <= wptr_q + cnt_ext;
			end
			if (pop) begin
				rptr_q <= rptr_q + cnt_ext;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= stat_nxt;
			moved_s1  <= (wr_go || rd_go) ? cnt : '0;
			rcount_s1 <= rd_go ? cnt : '0;
			used_s1   <= used_new;
			free_s1   <= cap_q - used_new;
			rbase_s1  <= rptr_q[BANK_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && s1_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s1_go) begin
			status_q <= status_s1;
			rdata_q  <= rd_bytes;
			moved_q  <= moved_s1;
			used_q   <= used_s1;
			free_q   <= free_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_bytes  = rdata_q;
	assign transferred = moved_q;
	assign used_count  = used_q;
	assign free_count  = free_q;

	`BRB_ASSERT_IMP(a_count_sum, clk, arst_n, out_valid,
		(11'(used_count) + 11'(free_count)) == 11'(cap_q), "used plus free differs from capacity")
	`BRB_ASSERT_IMP(a_err_empty, clk, arst_n, out_valid && (status != ST_OK),
		(transferred == '0) && (read_bytes == '0), "failed request moved data")
	`BRB_ASSERT_NXT(a_accept_s1, clk, arst_n, accept, valid_s1, "accepted request lost")
	`BRB_ASSERT_IMP(a_used_bound, clk, arst_n, 1'b1,
		used_cur <= cap_q, "stored bytes exceed capacity")

endmodule

// ===== src/brb_ram.sv =====
// ----------------------------------------------------------------------------
// brb_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module brb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold read data between requests
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
